// File: hw/rtl/rsamx_pkg.sv
// Package for the RSA byte modular exponentiation block.
// Holds the function codes, the queue entry type and fixed constants. No dependencies.
package rsamx_pkg;

   localparam logic FUNC_ENCRYPT = 1'b0;
   localparam logic FUNC_DECRYPT = 1'b1;

   localparam logic [1:0] CSR_PUB_EXP  = 2'd0;
   localparam logic [1:0] CSR_PRIV_EXP = 2'd1;
   localparam logic [1:0] CSR_MODULUS  = 2'd2;

   localparam int MIN_MODULUS = 255;
   localparam logic [7:0] BYTE_MASK = 8'hFF;

   // One classified job handed from the front end to the exponentiation engine.
   typedef struct packed {
      logic        func;
      logic        bad;
      logic [31:0] base;
      logic [31:0] exponent;
      logic [31:0] modulus;
   } job_type;

endpackage

// File: hw/rtl/rsamx_front.sv
// Front end: accepts transactions, selects base and exponent, flags a bad modulus
// and pushes jobs into a two-entry queue. Depends on rsamx_pkg.
module rsamx_front
   import rsamx_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  logic [7:0]           req_plain_byte,
   input  logic [WORD_BITS-1:0] req_cipher_word,
   input  logic [WORD_BITS-1:0] pub_exp,
   input  logic [WORD_BITS-1:0] priv_exp,
   input  logic [WORD_BITS-1:0] modulus,
   output logic                 job_valid,
   input  logic                 job_ready,
   output job_type              job
);

   job_type    q_ff [2];
   job_type    q_in;
   logic [1:0] count_ff, count_in;
   logic       rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic       push, pop;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign job_valid = (count_ff != 2'd0);
   assign pop       = job_valid && job_ready;
   assign job       = q_ff[rd_ptr_ff];

   always_comb begin
      q_in.func = req_func;
      q_in.bad  = ({{(32-WORD_BITS){1'b0}}, modulus} <= 32'(MIN_MODULUS));
      q_in.modulus = 32'(modulus);
      if (req_func == FUNC_ENCRYPT) begin
         q_in.base     = {24'd0, req_plain_byte};
         q_in.exponent = 32'(pub_exp);
      end else begin
         q_in.base     = 32'(req_cipher_word);
         q_in.exponent = 32'(priv_exp);
      end
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
   end

endmodule

// File: hw/rtl/rsamx_modred.sv
// Bit-serial reduction of a 64-bit value modulo a 32-bit modulus, one
// quotient bit a cycle. Depends on nothing.
module rsamx_modred (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   input  logic [31:0] modulus,
   output logic        done,
   output logic [31:0] remainder
);

   logic [32:0] rem_ff, rem_in;
   logic [63:0] val_ff, val_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] shifted;

   assign done      = done_ff;
   assign remainder = rem_ff[31:0];

   always_comb begin
      rem_in  = rem_ff;
      val_in  = val_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[31:0], val_ff[63]};
      if (start) begin
         rem_in  = 33'd0;
         val_in  = value;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = (shifted >= {1'b0, modulus}) ? shifted - {1'b0, modulus} : shifted;
         val_in = {val_ff[62:0], 1'b0};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      val_ff <= val_in;
      cnt_ff <= cnt_in;
   end

endmodule

// File: hw/rtl/rsamx_engine.sv
// Back end: square-and-multiply over the exponent bits with a shared
// bit-serial reducer, and a result register. Depends on rsamx_pkg, rsamx_modred.
module rsamx_engine
   import rsamx_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  job_type              job,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WORD_BITS-1:0] rsp_cipher_out,
   output logic [7:0]           rsp_plain_out,
   output logic                 rsp_bad_modulus
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_BASE = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_SQR  = 3'd3;
   localparam logic [2:0] ST_WAIT = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;
   localparam logic [2:0] ST_MRED = 3'd6;

   localparam int BIT_W = $clog2(WORD_BITS);

   logic [2:0]  state_ff, state_in, ret_ff, ret_in;
   logic [31:0] acc_ff, acc_in, sq_ff, sq_in, exp_ff, exp_in, mod_ff, mod_in;
   logic        func_ff, func_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic        red_start, red_done;
   logic [63:0] red_value;
   logic [31:0] red_rem;
   logic [31:0] prod_a, prod_b;
   logic        rsp_valid_ff, rsp_valid_in, bad_ff, bad_in;
   logic [31:0] cout_ff, cout_in;
   logic [7:0]  pout_ff, pout_in;
   logic [63:0] prod_ff;

   rsamx_modred u_red (
      .clock     (clock),
      .reset     (reset),
      .start     (red_start),
      .value     (red_value),
      .modulus   (mod_ff),
      .done      (red_done),
      .remainder (red_rem)
   );

   assign job_ready       = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cipher_out  = WORD_BITS'(cout_ff);
   assign rsp_plain_out   = pout_ff;
   assign rsp_bad_modulus = bad_ff;
   assign red_value       = prod_ff;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      exp_in       = exp_ff;
      mod_in       = mod_ff;
      func_in      = func_ff;
      bit_in       = bit_ff;
      red_start    = 1'b0;
      prod_a       = sq_ff;
      prod_b       = sq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      bad_in       = bad_ff;
      cout_in      = cout_ff;
      pout_in      = pout_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid && job_ready) begin
               func_in = job.func;
               if (job.bad) begin
                  rsp_valid_in = 1'b1;
                  bad_in  = 1'b1;
                  cout_in = 32'd0;
                  pout_in = 8'd0;
               end else begin
                  mod_in   = job.modulus;
                  exp_in   = job.exponent;
                  acc_in   = 32'd1;
                  sq_in    = job.base;
                  bit_in   = '0;
                  state_in = ST_BASE;
               end
            end
         end
         ST_BASE: begin
            // Product register holds base * 1; reduce it.
            red_start = 1'b1;
            ret_in    = ST_MUL;
            state_in  = ST_WAIT;
         end
         ST_MUL: begin
            // acc * sq if the bit is set, else sq * sq, is reduced in the next cycle.
            if (exp_ff[0]) begin
               prod_a   = acc_ff;
               state_in = ST_MRED;
            end else begin
               state_in = ST_SQR;
            end
         end
         ST_MRED: begin
            red_start = 1'b1;
            ret_in    = ST_SQR;
            state_in  = ST_WAIT;
         end
         ST_SQR: begin
            red_start = 1'b1;
            ret_in    = ST_OUT;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (red_done) begin
               if (ret_ff == ST_SQR) begin
                  acc_in   = red_rem;
                  state_in = ST_SQR;
               end else begin
                  sq_in    = red_rem;
                  state_in = ret_ff;
                  if (ret_ff == ST_OUT) begin
                     exp_in = {1'b0, exp_ff[31:1]};
                     bit_in = bit_ff + 1'b1;
                     state_in = (bit_ff == BIT_W'(WORD_BITS - 1)) ? ST_OUT : ST_MUL;
                  end
               end
            end
         end
         ST_OUT: begin
            // The modulus exceeds 255, so 1 mod n is 1 and acc needs no reduction.
            rsp_valid_in = 1'b1;
            bad_in       = 1'b0;
            cout_in      = (func_ff == FUNC_ENCRYPT) ? acc_ff : 32'd0;
            pout_in      = (func_ff == FUNC_DECRYPT) ? (acc_ff[7:0] & BYTE_MASK) : 8'd0;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ret_ff  <= ret_in;
      acc_ff  <= acc_in;
      sq_ff   <= sq_in;
      exp_ff  <= exp_in;
      mod_ff  <= mod_in;
      func_ff <= func_in;
      bit_ff  <= bit_in;
      bad_ff  <= bad_in;
      cout_ff <= cout_in;
      pout_ff <= pout_in;
      // The base enters as base * 1 so the first reduction takes it mod n.
      if (state_ff == ST_IDLE) begin
         prod_ff <= {32'd0, job.base};
      end else begin
         prod_ff <= prod_a * prod_b;
      end
   end

endmodule

// File: hw/rtl/rsa_byte_modexp_cipher.sv
// Top level of the RSA byte modular exponentiation block.
// Depends on rsamx_pkg, rsamx_front, rsamx_engine (and rsamx_modred below it).
//
//   Channel | Direction | Handshake          | Payload
//   req     | in        | req_valid/ready    | func, plain_byte, cipher_word
//   rsp     | out       | rsp_valid/ready    | cipher_out, plain_out, bad_modulus
//   csr     | in        | csr_valid/ready    | index, data
//
// Each job reduces the base, then per exponent bit multiplies if the bit is set
// and squares, each through the one bit-serial reducer. The engine takes a new job
// only when idle with no result pending; a bad modulus answers without the reducer.
// Reset is synchronous and clears state machines, queue pointers and key registers.
// A two-entry job queue lets the front accept while the engine works or its result
// waits on rsp_ready.
module rsa_byte_modexp_cipher
   import rsamx_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  logic [7:0]           req_plain_byte,
   input  logic [WORD_BITS-1:0] req_cipher_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WORD_BITS-1:0] rsp_cipher_out,
   output logic [7:0]           rsp_plain_out,
   output logic                 rsp_bad_modulus,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [WORD_BITS-1:0] csr_data
);

   logic [WORD_BITS-1:0] pub_exp_ff, priv_exp_ff, modulus_ff;
   logic    job_valid, job_ready;
   job_type job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pub_exp_ff  <= '0;
         priv_exp_ff <= '0;
         modulus_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PUB_EXP:  pub_exp_ff  <= csr_data;
            CSR_PRIV_EXP: priv_exp_ff <= csr_data;
            CSR_MODULUS:  modulus_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   rsamx_front #(.WORD_BITS(WORD_BITS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_plain_byte  (req_plain_byte),
      .req_cipher_word (req_cipher_word),
      .pub_exp         (pub_exp_ff),
      .priv_exp        (priv_exp_ff),
      .modulus         (modulus_ff),
      .job_valid       (job_valid),
      .job_ready       (job_ready),
      .job             (job)
   );

   rsamx_engine #(.WORD_BITS(WORD_BITS)) u_engine (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (job_valid),
      .job_ready       (job_ready),
      .job             (job),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cipher_out  (rsp_cipher_out),
      .rsp_plain_out   (rsp_plain_out),
      .rsp_bad_modulus (rsp_bad_modulus)
   );

endmodule

// File: hw/rtl/rsamx_checker.sv
// Port-level checks for the RSA block, bound to the top level.
// Depends on rsa_byte_modexp_cipher's ports only.
module rsamx_checker #(
   parameter int WORD_BITS = 32
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [WORD_BITS-1:0] rsp_cipher_out,
   input logic [7:0]           rsp_plain_out,
   input logic                 rsp_bad_modulus
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cipher_out))
      else $error("response dropped or changed while stalled");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_modulus |-> rsp_cipher_out == '0 && rsp_plain_out == 8'd0)
      else $error("bad modulus transaction carries a nonzero result");

   a_one_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cipher_out == '0 || rsp_plain_out == 8'd0)
      else $error("both result fields nonzero");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind rsa_byte_modexp_cipher rsamx_checker #(.WORD_BITS(WORD_BITS)) u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_cipher_out  (rsp_cipher_out),
   .rsp_plain_out   (rsp_plain_out),
   .rsp_bad_modulus (rsp_bad_modulus)
);

// File: tb/sv/tb_rsa_byte_modexp_cipher.sv
// Testbench for rsa_byte_modexp_cipher: encrypt and decrypt transactions under several key sets.
// Checks every response against a local square-and-multiply predictor.
// Depends on rsamx_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_rsa_byte_modexp_cipher;
   import rsamx_pkg::*;

   typedef struct packed {
      logic        func;
      logic [7:0]  plain_byte;
      logic [31:0] cipher_word;
   } crypt_request_type;

   typedef struct packed {
      logic [31:0] cipher_out;
      logic [7:0]  plain_out;
      logic        bad_modulus;
   } crypt_result_type;

   localparam longint CYCLE_LIMIT = 8_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = FUNC_ENCRYPT;
   logic [7:0]  req_plain_byte = 8'd0;
   logic [31:0] req_cipher_word = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_cipher_out;
   logic [7:0]  rsp_plain_out;
   logic        rsp_bad_modulus;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_PUB_EXP;
   logic [31:0] csr_data = 32'd0;

   crypt_request_type pending_requests[$];
   crypt_result_type  expected_results[$];
   crypt_request_type next_request;
   crypt_result_type  seen_result;
   crypt_result_type  want_result;

   // Local copy of the key registers.
   logic [31:0] key_public = 32'd0;
   logic [31:0] key_private = 32'd0;
   logic [31:0] key_modulus = 32'd0;

   int     req_gap = 0;
   int     rsp_gap = 0;
   bit     quiet = 1'b0;
   int     errors = 0;
   longint cycles = 0;

   rsa_byte_modexp_cipher dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_plain_byte(req_plain_byte), .req_cipher_word(req_cipher_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_cipher_out(rsp_cipher_out),
      .rsp_plain_out(rsp_plain_out), .rsp_bad_modulus(rsp_bad_modulus),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] power_mod(logic [31:0] base, logic [31:0] expo,
                                             logic [31:0] m);
      logic [63:0] acc;
      logic [63:0] sq;
      acc = 64'd1 % m;
      sq = base % m;
      for (int i = 0; i < 32; i++) begin
         if (expo[i])
            acc = (acc * sq) % m;
         sq = (sq * sq) % m;
      end
      return acc[31:0];
   endfunction

   function automatic crypt_result_type predict_result(crypt_request_type rq);
      crypt_result_type res;
      logic [31:0] word;
      res = '0;
      if (key_modulus <= MIN_MODULUS) begin
         res.bad_modulus = 1'b1;
      end else if (rq.func == FUNC_ENCRYPT) begin
         res.cipher_out = power_mod({24'd0, rq.plain_byte}, key_public, key_modulus);
      end else begin
         word = power_mod(rq.cipher_word, key_private, key_modulus);
         res.plain_out = word[7:0] & BYTE_MASK;
      end
      return res;
   endfunction

   // Request driver with random idle bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_results = {expected_results,
                                predict_result({req_func, req_plain_byte,
                                                req_cipher_word})};
         if (req_valid && !req_ready) begin
            // Hold the transaction until it is taken.
         end else if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_requests.size() > 0 && (quiet || $urandom_range(3) != 0)) begin
            next_request = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_func <= next_request.func;
            req_plain_byte <= next_request.plain_byte;
            req_cipher_word <= next_request.cipher_word;
         end else begin
            req_valid <= 1'b0;
            if (!quiet && pending_requests.size() > 0)
               req_gap <= $urandom_range(0, 8);
         end
      end
   end

   // Response monitor and checker, with random back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen_result = {rsp_cipher_out, rsp_plain_out, rsp_bad_modulus};
            if (expected_results.size() == 0) begin
               $display("%0t unexpected response cipher_out=%h plain_out=%h bad_modulus=%b",
                        $time, rsp_cipher_out, rsp_plain_out, rsp_bad_modulus);
               errors++;
            end else begin
               want_result = expected_results.pop_front();
               if (seen_result.cipher_out !== want_result.cipher_out) begin
                  $display("%0t cipher_out expected %h actual %h", $time,
                           want_result.cipher_out, seen_result.cipher_out);
                  errors++;
               end
               if (seen_result.plain_out !== want_result.plain_out) begin
                  $display("%0t plain_out expected %h actual %h", $time,
                           want_result.plain_out, seen_result.plain_out);
                  errors++;
               end
               if (seen_result.bad_modulus !== want_result.bad_modulus) begin
                  $display("%0t bad_modulus expected %b actual %b", $time,
                           want_result.bad_modulus, seen_result.bad_modulus);
                  errors++;
               end
            end
         end
         if (quiet) begin
            rsp_ready <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_ready <= 1'b0;
            rsp_gap <= rsp_gap - 1;
         end else if ($urandom_range(5) == 0) begin
            rsp_ready <= 1'b0;
            rsp_gap <= $urandom_range(0, 8);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic write_register(logic [1:0] index, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_PUB_EXP:  key_public = value;
         CSR_PRIV_EXP: key_private = value;
         CSR_MODULUS:  key_modulus = value;
         default: ;
      endcase
   endtask

   task automatic load_keys(logic [31:0] pub, logic [31:0] priv, logic [31:0] m);
      write_register(CSR_PUB_EXP, pub);
      write_register(CSR_PRIV_EXP, priv);
      write_register(CSR_MODULUS, m);
   endtask

   task automatic add_request(logic func, logic [7:0] plain, logic [31:0] word);
      crypt_request_type rq;
      rq = {func, plain, word};
      pending_requests = {pending_requests, rq};
   endtask

   task automatic add_random(int count);
      for (int i = 0; i < count; i++)
         add_request(1'($urandom_range(1)), 8'($urandom_range(255)), $urandom());
   endtask

   // Waits until every transaction has been answered and the block has settled.
   task automatic drain();
      do @(posedge clock);
      while (pending_requests.size() > 0 || req_valid || expected_results.size() > 0);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Registers still at reset: the zero modulus is rejected.
      add_request(FUNC_ENCRYPT, 8'hFF, 32'hFFFF_FFFF);
      add_request(FUNC_DECRYPT, 8'h00, 32'hFFFF_FFFF);
      drain();

      // Zero exponents on the smallest accepted modulus.
      load_keys(32'd0, 32'd0, 32'd256);
      add_request(FUNC_ENCRYPT, 8'd0, 32'd0);
      add_request(FUNC_DECRYPT, 8'd0, 32'd0);
      add_request(FUNC_DECRYPT, 8'hFF, 32'hFFFF_FFFF);
      drain();

      // The largest rejected modulus.
      load_keys(32'd1, 32'd1, 32'd255);
      add_request(FUNC_ENCRYPT, 8'd7, 32'd9);
      add_request(FUNC_DECRYPT, 8'd7, 32'd9);
      drain();

      // All-ones keys.
      load_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_request(FUNC_ENCRYPT, 8'd0, 32'hFFFF_FFFF);
      add_request(FUNC_ENCRYPT, 8'hFF, 32'd0);
      add_request(FUNC_ENCRYPT, 8'd1, 32'd5);
      add_request(FUNC_DECRYPT, 8'hFF, 32'hFFFF_FFFF);
      add_request(FUNC_DECRYPT, 8'h00, 32'hFFFF_FFFE);
      add_request(FUNC_DECRYPT, 8'h00, 32'd0);
      add_request(FUNC_DECRYPT, 8'h00, 32'd1);
      add_random(8);
      drain();

      // Exponent of one; the decrypt word lies above the modulus and needs reducing.
      load_keys(32'd1, 32'd1, 32'd257);
      add_request(FUNC_ENCRYPT, 8'hFF, 32'd0);
      add_request(FUNC_DECRYPT, 8'd0, 32'hFFFF_FFFF);
      add_random(6);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 5)
            quiet = 1'b1;
         load_keys($urandom(), $urandom(),
                   (phase == 2) ? 32'($urandom_range(255)) : ($urandom() | 32'h100));
         add_random(20);
         drain();
      end

      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
